FILE: design/lbsa_pkg.sv
// ----------------------------------------------------------------------------
// lbsa_pkg: shared types and constants for the labelled block sum accumulator
// Word formats on both channels, the internal command word passed from the
// front to the back, op codes and saturation limits.
// ----------------------------------------------------------------------------
package lbsa_pkg;

  // Store sizes and field widths
  localparam int unsigned NODES    = 1024;
  localparam int unsigned LABELS   = 16;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned LABEL_W  = 4;
  localparam int unsigned BLOCK_W  = 2 * LABEL_W;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned PAIR_W   = 21;

  // Op codes (also used as command kinds)
  localparam logic [1:0] OP_LABEL = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [PAIR_W-1:0]  PAIR_MAX  = '1;

  typedef struct packed {
    logic [1:0]          op;
    logic [NODE_W-1:0]   row_node;
    logic [NODE_W-1:0]   col_node;
    logic [LABEL_W-1:0]  node_label_in;
    logic [WEIGHT_W-1:0] weight;
    logic [LABEL_W-1:0]  block_row;
    logic [LABEL_W-1:0]  block_col;
  } in_word_t;

  typedef struct packed {
    logic [SUM_W-1:0]  block_total;
    logic [PAIR_W-1:0] pair_total;
  } out_word_t;

  // Command word: labels already resolved by the front
  typedef struct packed {
    logic [1:0]          kind;
    logic [LABEL_W-1:0]  lab_a;
    logic [LABEL_W-1:0]  lab_b;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

  // Back status
  typedef struct packed {
    logic exec;
    logic exec_query;
  } bk_stat_t;

endpackage

FILE: design/lbsa_front.sv
// ----------------------------------------------------------------------------
// lbsa_front: input stage with the node label store
// Accepts words, writes node labels and looks up the labels of an entry's
// row and column nodes, then hands a resolved command word to the queue.
// ----------------------------------------------------------------------------
module lbsa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lbsa_pkg::in_word_t in_word_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output lbsa_pkg::cmd_t    cmd_o
);

  logic [lbsa_pkg::LABEL_W-1:0] label_mem [lbsa_pkg::NODES];
  logic [lbsa_pkg::LABEL_W-1:0] row_lab_q;
  logic [lbsa_pkg::LABEL_W-1:0] col_lab_q;
  lbsa_pkg::in_word_t           s1_word_q;
  logic                         s1_valid_q;
  logic                         accept;

  assign in_ready_o  = !s1_valid_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = s1_valid_q;

  // Label store: write on label op, both lookups registered on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (in_word_i.op == lbsa_pkg::OP_LABEL) begin
        label_mem[in_word_i.row_node] <= in_word_i.node_label_in;
      end
      row_lab_q <= label_mem[in_word_i.row_node];
      col_lab_q <= label_mem[in_word_i.col_node];
      s1_word_q <= in_word_i;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Build the command word
  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = s1_word_q.op;
    cmd_o.weight = s1_word_q.weight;
    case (s1_word_q.op)
      lbsa_pkg::OP_LABEL: begin
        cmd_o.lab_a = s1_word_q.node_label_in;
      end
      lbsa_pkg::OP_ADD: begin
        cmd_o.lab_a = row_lab_q;
        cmd_o.lab_b = col_lab_q;
      end
      lbsa_pkg::OP_QUERY: begin
        cmd_o.lab_a = s1_word_q.block_row;
        cmd_o.lab_b = s1_word_q.block_col;
      end
      default: begin
        cmd_o.lab_a = '0;
      end
    endcase
  end

endmodule

FILE: design/lbsa_fifo.sv
// ----------------------------------------------------------------------------
// lbsa_fifo: command queue between front and back
// Small first-in first-out buffer so either side can stall on its own.
// ----------------------------------------------------------------------------
module lbsa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lbsa_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lbsa_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W:0] FULL = (PTR_W + 1)'(DEPTH);

  lbsa_pkg::cmd_t   store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   fill_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (fill_q != FULL);
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = store_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/lbsa_back.sv
// ----------------------------------------------------------------------------
// lbsa_back: execution stage with label counts and block sums
// Reads the count and sum stores as a command is taken, updates them in the
// following cycle with a bypass of the last write, and forms query results.
// ----------------------------------------------------------------------------
module lbsa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  lbsa_pkg::cmd_t      cmd_i,
  input  logic                halve_diag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lbsa_pkg::out_word_t out_word_o,
  output lbsa_pkg::bk_stat_t  stat_o
);

  localparam int unsigned BLOCKS = lbsa_pkg::LABELS * lbsa_pkg::LABELS;
  localparam int unsigned PROD_W = 2 * lbsa_pkg::COUNT_W;

  // Stores and their valid bits (clear drops all valid bits at once)
  logic [lbsa_pkg::SUM_W-1:0]   sum_mem [BLOCKS];
  logic [lbsa_pkg::COUNT_W-1:0] cnt_mem [lbsa_pkg::LABELS];
  logic [BLOCKS-1:0]            sum_vld_q;
  logic [lbsa_pkg::LABELS-1:0]  cnt_vld_q;

  // Execution register with registered store reads
  logic                         ex_valid_q;
  lbsa_pkg::cmd_t               ex_cmd_q;
  logic [lbsa_pkg::SUM_W-1:0]   sum_rd_q;
  logic [lbsa_pkg::COUNT_W-1:0] cnt_a_rd_q;
  logic [lbsa_pkg::COUNT_W-1:0] cnt_b_rd_q;

  // Bypass of the last write to each store
  logic                         sum_fwd_vld_q;
  logic [lbsa_pkg::BLOCK_W-1:0] sum_fwd_idx_q;
  logic [lbsa_pkg::SUM_W-1:0]   sum_fwd_q;
  logic                         cnt_fwd_vld_q;
  logic [lbsa_pkg::LABEL_W-1:0] cnt_fwd_idx_q;
  logic [lbsa_pkg::COUNT_W-1:0] cnt_fwd_q;

  logic                out_valid_q;
  lbsa_pkg::out_word_t out_word_q;

  logic                         is_query;
  logic                         exec;
  logic                         pop;
  logic [lbsa_pkg::BLOCK_W-1:0] ex_idx;
  logic [lbsa_pkg::SUM_W-1:0]   sum_old;
  logic [lbsa_pkg::COUNT_W-1:0] cnt_a_old;
  logic [lbsa_pkg::COUNT_W-1:0] cnt_b_old;
  logic [lbsa_pkg::SUM_W:0]     sum_add;
  logic [lbsa_pkg::SUM_W-1:0]   sum_new;
  logic [lbsa_pkg::COUNT_W-1:0] cnt_new;
  logic                         diag;
  logic                         halve;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W-1:0]            pairs_raw;
  logic [PROD_W-1:0]            pairs_h;
  lbsa_pkg::out_word_t          result;

  assign is_query    = (ex_cmd_q.kind == lbsa_pkg::OP_QUERY);
  assign exec        = ex_valid_q && (!is_query || !out_valid_q || out_ready_i);
  assign cmd_ready_o = !ex_valid_q || exec;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign ex_idx      = {ex_cmd_q.lab_a, ex_cmd_q.lab_b};

  // Current values: bypass first, then store if valid, else zero
  always_comb begin
    if (sum_fwd_vld_q && sum_fwd_idx_q == ex_idx) begin
      sum_old = sum_fwd_q;
    end else if (sum_vld_q[ex_idx]) begin
      sum_old = sum_rd_q;
    end else begin
      sum_old = '0;
    end
    if (cnt_fwd_vld_q && cnt_fwd_idx_q == ex_cmd_q.lab_a) begin
      cnt_a_old = cnt_fwd_q;
    end else if (cnt_vld_q[ex_cmd_q.lab_a]) begin
      cnt_a_old = cnt_a_rd_q;
    end else begin
      cnt_a_old = '0;
    end
    if (cnt_fwd_vld_q && cnt_fwd_idx_q == ex_cmd_q.lab_b) begin
      cnt_b_old = cnt_fwd_q;
    end else if (cnt_vld_q[ex_cmd_q.lab_b]) begin
      cnt_b_old = cnt_b_rd_q;
    end else begin
      cnt_b_old = '0;
    end
  end

  // Saturating updates
  assign sum_add = {1'b0, sum_old} + (lbsa_pkg::SUM_W + 1)'(ex_cmd_q.weight);
  assign sum_new = sum_add[lbsa_pkg::SUM_W] ? lbsa_pkg::SUM_MAX
                                            : sum_add[lbsa_pkg::SUM_W-1:0];
  assign cnt_new = (cnt_a_old == lbsa_pkg::COUNT_MAX) ? cnt_a_old
                                                      : cnt_a_old + 1'b1;

  // Query result: pair count, diagonal correction, halving, saturation
  assign diag      = (ex_cmd_q.lab_a == ex_cmd_q.lab_b);
  assign halve     = diag && halve_diag_i;
  assign prod      = PROD_W'(cnt_a_old) * PROD_W'(cnt_b_old);
  assign pairs_raw = diag ? prod - PROD_W'(cnt_a_old) : prod;
  assign pairs_h   = halve ? (pairs_raw >> 1) : pairs_raw;

  always_comb begin
    result.block_total = halve ? (sum_old >> 1) : sum_old;
    result.pair_total  = (pairs_h[PROD_W-1:lbsa_pkg::PAIR_W] != '0)
                         ? lbsa_pkg::PAIR_MAX : pairs_h[lbsa_pkg::PAIR_W-1:0];
  end

  // Stores, reads on pop, payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      ex_cmd_q   <= cmd_i;
      sum_rd_q   <= sum_mem[{cmd_i.lab_a, cmd_i.lab_b}];
      cnt_a_rd_q <= cnt_mem[cmd_i.lab_a];
      cnt_b_rd_q <= cnt_mem[cmd_i.lab_b];
    end
    if (exec && ex_cmd_q.kind == lbsa_pkg::OP_ADD) begin
      sum_mem[ex_idx] <= sum_new;
      sum_fwd_idx_q   <= ex_idx;
      sum_fwd_q       <= sum_new;
    end
    if (exec && ex_cmd_q.kind == lbsa_pkg::OP_LABEL) begin
      cnt_mem[ex_cmd_q.lab_a] <= cnt_new;
      cnt_fwd_idx_q           <= ex_cmd_q.lab_a;
      cnt_fwd_q               <= cnt_new;
    end
    if (exec && is_query) begin
      out_word_q <= result;
    end
  end

  // Control: stage valid, valid bits, bypass valids, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q    <= 1'b0;
      sum_vld_q     <= '0;
      cnt_vld_q     <= '0;
      sum_fwd_vld_q <= 1'b0;
      cnt_fwd_vld_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_ready_o) begin
        ex_valid_q <= cmd_valid_i;
      end
      if (exec) begin
        case (ex_cmd_q.kind)
          lbsa_pkg::OP_ADD: begin
            sum_vld_q[ex_idx] <= 1'b1;
            sum_fwd_vld_q     <= 1'b1;
          end
          lbsa_pkg::OP_LABEL: begin
            cnt_vld_q[ex_cmd_q.lab_a] <= 1'b1;
            cnt_fwd_vld_q             <= 1'b1;
          end
          lbsa_pkg::OP_CLEAR: begin
            sum_vld_q     <= '0;
            cnt_vld_q     <= '0;
            sum_fwd_vld_q <= 1'b0;
            cnt_fwd_vld_q <= 1'b0;
          end
          default: begin
            sum_fwd_vld_q <= sum_fwd_vld_q;
          end
        endcase
      end
      if (exec && is_query) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;
  assign stat_o.exec       = exec;
  assign stat_o.exec_query = exec && is_query;

endmodule

FILE: design/labelled_block_sum_accumulator.sv
// Results: a query passes the front stage, the command queue and the back's
//   execution register; label writes, entry adds and clears give no result.
// Throughput: one word per cycle for every op, a clear included, while no
//   query stalls on out_ready_i; the bypassed sum store update sets the rate.
// Reset: label counts and block sums read zero, halve_diagonal is 1; node
//   labels are undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
// labelled_block_sum_accumulator: top level
// Front (label store), command queue and back (counts, sums, results), plus
// the halve_diagonal register.
// ----------------------------------------------------------------------------
module labelled_block_sum_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lbsa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lbsa_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  logic               halve_diag_q;
  logic               fr_valid;
  logic               fr_ready;
  lbsa_pkg::cmd_t     fr_cmd;
  logic               bk_valid;
  logic               bk_ready;
  lbsa_pkg::cmd_t     bk_cmd;
  lbsa_pkg::bk_stat_t bk_stat;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halve_diag_q <= 1'b1;
    end else if (cfg_valid_i) begin
      halve_diag_q <= cfg_data_i;
    end
  end

  lbsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  lbsa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_cmd_o    (bk_cmd)
  );

  lbsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (bk_valid),
    .cmd_ready_o  (bk_ready),
    .cmd_i        (bk_cmd),
    .halve_diag_i (halve_diag_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .stat_o       (bk_stat)
  );

  // A command word stalled at the queue holds until taken
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid && !fr_ready |=> fr_valid && $stable(fr_cmd))
    else $error("front command changed while stalled");

  // A result only appears after a query executes
  a_out_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.exec_query))
    else $error("result without an executed query");

  // No query executes into an output word that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !bk_stat.exec_query)
    else $error("query overwrote a pending result");

  // An executed query also counts as an execution of the back
  a_exec_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.exec_query |-> bk_stat.exec)
    else $error("query executed without a command");

endmodule
